FILE: design/rcfd_pkg.sv
`timescale 1ns / 1ps

package rcfd_pkg;

   // Frame layout.
   localparam int FRAME_LEN      = 32;
   localparam int SUM_LEN        = 30;
   localparam int COUNT_MAX      = 33;
   localparam int CKS_LO_POS     = 30;
   localparam int FIRST_PAIR_POS = 3;
   localparam int LAST_PLAIN_POS = 29;
   localparam int LAST_EXT_POS   = 25;
   localparam int PLAIN_CHANNELS = 14;
   localparam int EXT_CHANNELS   = 4;
   localparam int NUM_CHANNELS   = 18;

   localparam logic [7:0]  HEAD_0   = 8'h20;
   localparam logic [7:0]  HEAD_1   = 8'h40;
   localparam logic [15:0] SUM_INV  = 16'hFFFF;
   localparam logic [4:0]  LAST_IDX = 5'(NUM_CHANNELS - 1);

   // Which part of an extended channel a byte's high nibble fills.
   typedef enum logic [1:0] {
      PART_LOW,
      PART_MID,
      PART_HIGH
   } ext_part_type;

   // Where the byte at one frame position lands in the channel bank.
   typedef struct packed {
      logic         plain_we;
      logic [3:0]   plain_idx;
      logic         ext_we;
      logic [1:0]   ext_idx;
      ext_part_type ext_part;
   } byte_slot_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic advance;
   } rcfd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_good;
      logic at_last;
   } rcfd_status_type;

   // Decode a frame position into its channel write slots.
   function automatic byte_slot_type byte_slot(input logic [4:0] pos);
      byte_slot_type s;
      logic [4:0]    m;
      m = pos - 5'(FIRST_PAIR_POS);
      s.plain_we  = pos[0] && (pos >= 5'(FIRST_PAIR_POS)) && (pos <= 5'(LAST_PLAIN_POS));
      s.plain_idx = m[4:1];
      s.ext_we    = pos[0] && (pos >= 5'(FIRST_PAIR_POS)) && (pos <= 5'(LAST_EXT_POS));
      case (m[4:1])
         4'd0: begin
            s.ext_idx = 2'd0; s.ext_part = PART_LOW;
         end
         4'd1: begin
            s.ext_idx = 2'd0; s.ext_part = PART_MID;
         end
         4'd2: begin
            s.ext_idx = 2'd0; s.ext_part = PART_HIGH;
         end
         4'd3: begin
            s.ext_idx = 2'd1; s.ext_part = PART_LOW;
         end
         4'd4: begin
            s.ext_idx = 2'd1; s.ext_part = PART_MID;
         end
         4'd5: begin
            s.ext_idx = 2'd1; s.ext_part = PART_HIGH;
         end
         4'd6: begin
            s.ext_idx = 2'd2; s.ext_part = PART_LOW;
         end
         4'd7: begin
            s.ext_idx = 2'd2; s.ext_part = PART_MID;
         end
         4'd8: begin
            s.ext_idx = 2'd2; s.ext_part = PART_HIGH;
         end
         4'd9: begin
            s.ext_idx = 2'd3; s.ext_part = PART_LOW;
         end
         4'd10: begin
            s.ext_idx = 2'd3; s.ext_part = PART_MID;
         end
         4'd11: begin
            s.ext_idx = 2'd3; s.ext_part = PART_HIGH;
         end
         default: begin
            s.ext_idx = 2'd0; s.ext_part = PART_LOW;
         end
      endcase
      return s;
   endfunction

endpackage

FILE: design/rcfd_dpath.sv
`timescale 1ns / 1ps

module rcfd_dpath import rcfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      req_data_byte,
   input  logic            req_end_of_buffer,
   input  rcfd_cmd_type    cmd,
   output rcfd_status_type status,
   output logic [4:0]      rsp_channel_index,
   output logic [10:0]     rsp_channel_value,
   output logic            rsp_last_channel
);

   logic [5:0]    count_ff, count_in;
   logic [15:0]   sum_ff, sum_in;
   logic          hdr_ok_ff, hdr_ok_in;
   logic [7:0]    cks_lo_ff, cks_lo_in;
   logic [7:0]    prev_ff, prev_in;
   logic [4:0]    idx_ff, idx_in;
   logic [10:0]   chan_ff [NUM_CHANNELS];
   logic [10:0]   chan_in [NUM_CHANNELS];
   logic          in_frame;
   logic [4:0]    pos;
   byte_slot_type slot;
   logic          at_last;

   assign in_frame = count_ff < 6'(FRAME_LEN);
   assign pos      = count_ff[4:0];
   assign slot     = byte_slot(pos);
   assign at_last  = idx_ff == LAST_IDX;

   // The frame is good when its last byte completes the length, header and checksum.
   assign status.frame_good = req_end_of_buffer
                              && (count_ff == 6'(FRAME_LEN - 1))
                              && hdr_ok_ff
                              && ({req_data_byte, cks_lo_ff} == (sum_ff ^ SUM_INV));
   assign status.at_last = at_last;

   // Byte intake: channel values are assembled as the bytes arrive.
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      hdr_ok_in = hdr_ok_ff;
      cks_lo_in = cks_lo_ff;
      prev_in   = prev_ff;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_in[i] = chan_ff[i];
      end
      if (cmd.take) begin
         prev_in = req_data_byte;
         if (in_frame) begin
            if (pos == 5'd0) begin
               hdr_ok_in = req_data_byte == HEAD_0;
            end
            if (pos == 5'd1) begin
               hdr_ok_in = hdr_ok_ff && (req_data_byte == HEAD_1);
            end
            if (pos == 5'(CKS_LO_POS)) begin
               cks_lo_in = req_data_byte;
            end
            for (int i = 0; i < PLAIN_CHANNELS; i++) begin
               if (slot.plain_we && (slot.plain_idx == 4'(i))) begin
                  chan_in[i] = {req_data_byte[2:0], prev_ff};
               end
            end
            for (int j = 0; j < EXT_CHANNELS; j++) begin
               if (slot.ext_we && (slot.ext_idx == 2'(j))) begin
                  case (slot.ext_part)
                     PART_LOW: begin
                        chan_in[PLAIN_CHANNELS + j][3:0] = req_data_byte[7:4];
                     end
                     PART_MID: begin
                        chan_in[PLAIN_CHANNELS + j][7:4] = req_data_byte[7:4];
                     end
                     PART_HIGH: begin
                        chan_in[PLAIN_CHANNELS + j][10:8] = req_data_byte[6:4];
                     end
                     default: begin
                        chan_in[PLAIN_CHANNELS + j] = chan_ff[PLAIN_CHANNELS + j];
                     end
                  endcase
               end
            end
         end
         if (count_ff < 6'(SUM_LEN)) begin
            sum_in = sum_ff + {8'd0, req_data_byte};
         end
         if (count_ff < 6'(COUNT_MAX)) begin
            count_in = count_ff + 6'd1;
         end
         if (req_end_of_buffer) begin
            count_in = '0;
            sum_in   = '0;
         end
      end
   end

   // Response index steps through the channel bank.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.advance) begin
         idx_in = at_last ? 5'd0 : idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         hdr_ok_ff <= hdr_ok_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cks_lo_ff <= cks_lo_in;
      prev_ff   <= prev_in;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_ff[i] <= chan_in[i];
      end
   end

   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = chan_ff[idx_ff];
   assign rsp_last_channel  = at_last;

   // The byte count never passes its saturation point.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 6'(COUNT_MAX))
      else $error("byte count above saturation");

   // The response index stays inside the channel range.
   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("channel index out of range");

   // A transfer that is not the last one moves to the next channel.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.advance && !at_last) |=> (idx_ff == $past(idx_ff) + 5'd1))
      else $error("channel index did not advance");

endmodule

FILE: design/rcfd_ctrl.sv
`timescale 1ns / 1ps

module rcfd_ctrl import rcfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  rcfd_status_type status,
   output rcfd_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_EMIT;

   assign cmd.take    = req_valid && req_ready;
   assign cmd.advance = rsp_valid && rsp_ready;

   // Take bytes until a good frame ends, then drain its channels.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && status.frame_good) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.advance && status.at_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Input and output never run at the same time.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and output active together");

   // A good frame starts the channel burst.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status.frame_good) |=> rsp_valid)
      else $error("good frame did not start output");

   // The last channel transfer reopens the input.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.advance && status.at_last) |=> req_ready)
      else $error("input not reopened after last channel");

endmodule

FILE: design/rc_channel_frame_decoder_core.sv
`timescale 1ns / 1ps

// Decoder for a 32-byte serial RC frame carrying 18 eleven-bit channels. The
// channel values are assembled in a register bank as the bytes arrive. When the
// byte marked end of buffer closes a frame of exactly 32 bytes with header 0x20
// 0x40 and a checksum (inverted 16-bit sum of bytes 0 to 29, little-endian in
// bytes 30 and 31) that matches, the block sends channels 0 to 17 in order, one
// per response transfer, read from the bank, with last_channel set on channel 17.
// During that burst the input is held off until the channel 17 transfer, also
// while the response side stalls. A rejected frame gives no responses and costs
// nothing extra.

module rc_channel_frame_decoder_core import rcfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_channel_index,
   output logic [10:0] rsp_channel_value,
   output logic        rsp_last_channel
);

   rcfd_cmd_type    cmd;
   rcfd_status_type status;

   rcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcfd_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_data_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .cmd               (cmd),
      .status            (status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
